// ----- src/sha256_pkg.sv -----
package sha256_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;
	localparam int unsigned QueueDepthDefault = 4;

	typedef logic [WordW-1:0] word_t;

	// front to back: one finished 512-bit block
	typedef struct packed {
		logic                          final_blk;
		logic [BlockWords*WordW-1:0]   data;
	} blk_t;

	typedef enum logic [3:0] {
		FR_BYTES = 4'b0001,
		FR_PAD   = 4'b0010,
		FR_LEN   = 4'b0100,
		FR_PUSH  = 4'b1000
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_ROUND = 3'b010,
		BK_OUT   = 3'b100
	} bk_state_t;

	localparam word_t HInit [DigestWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

// ----- src/sha256_if.sv -----
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha256_front.sv -----
// Packs bytes into blocks, pads, appends the length.
module sha256_front (
	input  logic               clk,
	input  logic               arst_n,
	sha256_in_if.sink          in_ch,
	output logic               blk_valid,
	input  logic               blk_ready,
	output sha256_pkg::blk_t   blk
);
	sha256_pkg::fr_state_t state_q;
	logic [5:0]  pos_q;
	logic [63:0] len_q;
	logic [511:0] buf_q;
	logic        final_q;
	logic        after_q; // state to resume after push: pad continues
	logic        pad_pend_q; // set when a block is pushed mid-padding
	logic [7:0]  byte_d;
	logic        wr;

	assign in_ch.ready = (state_q == sha256_pkg::FR_BYTES);
	assign blk_valid = (state_q == sha256_pkg::FR_PUSH);
	assign blk.data = buf_q;
	assign blk.final_blk = final_q;

	always_comb begin
		byte_d = 8'h00;
		wr = 1'b0;
		case (state_q)
			sha256_pkg::FR_BYTES: begin
				wr = in_ch.valid && in_ch.has_byte;
				byte_d = in_ch.msg_byte;
			end
			sha256_pkg::FR_PAD: begin
				wr = 1'b1;
				byte_d = 8'h00;
			end
			sha256_pkg::FR_LEN: begin
				wr = 1'b1;
				byte_d = len_q[63 - 8*pos_q[2:0] -: 8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::FR_BYTES;
			pos_q <= '0;
			len_q <= '0;
			final_q <= 1'b0;
			after_q <= 1'b0;
		end else begin
			case (state_q)
				sha256_pkg::FR_BYTES: begin
					if (in_ch.valid) begin
						if (in_ch.end_of_message) begin
							// byte (if any) then marker; marker position
							if (in_ch.has_byte) begin
								len_q <= len_q + 64'd8;
								if (pos_q == 6'd63) begin
									buf_q[511 - 8*pos_q -: 8] <= in_ch.msg_byte;
									final_q <= 1'b0;
									after_q <= 1'b1;
									state_q <= sha256_pkg::FR_PUSH;
									pos_q <= 6'd0;
								end else begin
									buf_q[511 - 8*pos_q -: 16] <=
										{in_ch.msg_byte, sha256_pkg::PadByte};
									pos_q <= pos_q + 6'd2;
									if (pos_q == 6'd62) begin
										final_q <= 1'b0;
										after_q <= 1'b0;
										state_q <= sha256_pkg::FR_PUSH;
									end else begin
										state_q <= sha256_pkg::FR_PAD;
									end
								end
							end else begin
								buf_q[511 - 8*pos_q -: 8] <= sha256_pkg::PadByte;
								pos_q <= pos_q + 6'd1;
								if (pos_q == 6'd63) begin
									final_q <= 1'b0;
									after_q <= 1'b0;
									state_q <= sha256_pkg::FR_PUSH;
								end else begin
									state_q <= sha256_pkg::FR_PAD;
								end
							end
						end else if (in_ch.has_byte) begin
							buf_q[511 - 8*pos_q -: 8] <= in_ch.msg_byte;
							len_q <= len_q + 64'd8;
							pos_q <= pos_q + 6'd1;
							if (pos_q == 6'd63) begin
								final_q <= 1'b0;
								after_q <= 1'b0;
								state_q <= sha256_pkg::FR_PUSH;
							end
						end
					end
				end
				sha256_pkg::FR_PAD: begin
					if (pos_q == 6'd56) begin
						state_q <= sha256_pkg::FR_LEN;
					end else begin
						buf_q[511 - 8*pos_q -: 8] <= byte_d;
						pos_q <= pos_q + 6'd1;
						if (pos_q == 6'd63) begin
							final_q <= 1'b0;
							after_q <= 1'b0;
							state_q <= sha256_pkg::FR_PUSH;
							// pad goes on in the next block
						end
					end
				end
				sha256_pkg::FR_LEN: begin
					buf_q[511 - 8*pos_q -: 8] <= byte_d;
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						final_q <= 1'b1;
						state_q <= sha256_pkg::FR_PUSH;
					end
				end
				sha256_pkg::FR_PUSH: begin
					if (blk_ready) begin
						if (final_q) begin
							len_q <= '0;
							final_q <= 1'b0;
							state_q <= sha256_pkg::FR_BYTES;
						end else if (after_q) begin
							// full block then marker in a new block
							buf_q[511 -: 8] <= sha256_pkg::PadByte;
							pos_q <= 6'd1;
							after_q <= 1'b0;
							state_q <= sha256_pkg::FR_PAD;
						end else if (pad_pend_q) begin
							state_q <= sha256_pkg::FR_PAD;
						end else begin
							state_q <= sha256_pkg::FR_BYTES;
						end
					end
				end
				default: state_q <= sha256_pkg::FR_BYTES;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_pend_q <= 1'b0;
		end else if (state_q == sha256_pkg::FR_PUSH && blk_ready) begin
			pad_pend_q <= 1'b0;
		end else if (state_q != sha256_pkg::FR_PUSH && state_q != sha256_pkg::FR_BYTES
				&& wr && pos_q == 6'd63) begin
			pad_pend_q <= 1'b1;
		end else if (state_q == sha256_pkg::FR_BYTES && in_ch.valid && in_ch.end_of_message
				&& pos_q >= 6'd62) begin
			pad_pend_q <= !(in_ch.has_byte && pos_q == 6'd63);
		end
	end
endmodule

// ----- src/sha256_queue.sv -----
// Small block FIFO between front and back.
module sha256_queue #(
	parameter int unsigned Depth = sha256_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sha256_pkg::blk_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sha256_pkg::blk_t rd_data
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	sha256_pkg::blk_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != Depth[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// ----- src/sha256_back.sv -----
// One round per cycle compression, then digest word output.
module sha256_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             blk_valid,
	output logic             blk_ready,
	input  sha256_pkg::blk_t blk,
	sha256_out_if.source     out_ch
);
	sha256_pkg::bk_state_t state_q;
	sha256_pkg::word_t h_q [8];
	sha256_pkg::word_t v_q [8];
	sha256_pkg::word_t w_q [16];
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;
	sha256_pkg::word_t wn, s0, s1, ch, mj, t1, t2, g0, g1;

	assign blk_ready = (state_q == sha256_pkg::BK_IDLE);
	assign out_ch.valid = (state_q == sha256_pkg::BK_OUT);
	assign out_ch.digest_word = h_q[idx_q];
	assign out_ch.word_index = idx_q;
	assign out_ch.last_word = (idx_q == 3'd7);

	always_comb begin
		// window slides: w_q[0] is the current word
		g0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		g1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + g0 + w_q[9] + g1;
		s1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + sha256_pkg::round_k(rnd_q) + w_q[0];
		s0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	always_ff @(posedge clk) begin
		if (state_q == sha256_pkg::BK_IDLE && blk_valid) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk.data[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == sha256_pkg::BK_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::BK_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::HInit[i];
		end else begin
			case (state_q)
				sha256_pkg::BK_IDLE: begin
					if (blk_valid) begin
						fin_q <= blk.final_blk;
						rnd_q <= '0;
						state_q <= sha256_pkg::BK_ROUND;
					end
				end
				sha256_pkg::BK_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= fin_q ? sha256_pkg::BK_OUT : sha256_pkg::BK_IDLE;
						idx_q <= '0;
					end
				end
				sha256_pkg::BK_OUT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::HInit[i];
							state_q <= sha256_pkg::BK_IDLE;
						end
					end
				end
				default: state_q <= sha256_pkg::BK_IDLE;
			endcase
			// fold working vars in once rounds finish
			if (state_q == sha256_pkg::BK_ROUND && rnd_q == 6'd63) begin
				h_q[0] <= h_q[0] + t1 + t2;
				h_q[1] <= h_q[1] + v_q[0];
				h_q[2] <= h_q[2] + v_q[1];
				h_q[3] <= h_q[3] + v_q[2];
				h_q[4] <= h_q[4] + v_q[3] + t1;
				h_q[5] <= h_q[5] + v_q[4];
				h_q[6] <= h_q[6] + v_q[5];
				h_q[7] <= h_q[7] + v_q[6];
			end
		end
	end
endmodule

// ----- src/sha256_message_hasher_core.sv -----
// Channel | Dir | Word fields
// in_ch   | in  | msg_byte[7:0], has_byte, end_of_message
// out_ch  | out | digest_word[31:0], word_index[2:0], last_word
//
// Front takes one byte per cycle, but not while it pads or pushes a block;
// a full block is pushed into a block queue. Back loads a block while idle,
// then compresses it one round per cycle; the round unit sets the rate.
// End of message adds padding and the length, then 8 digest words.
// arst_n clears control state and the hash value to the initial constants.
// A full queue stalls the front; a held out_ch stalls the back and front.
module sha256_message_hasher_core #(
	parameter int unsigned QueueDepth = sha256_pkg::QueueDepthDefault
) (
	input logic          clk,
	input logic          arst_n,
	sha256_in_if.sink    in_ch,
	sha256_out_if.source out_ch
);
	logic f_valid, f_ready, b_valid, b_ready;
	sha256_pkg::blk_t f_blk, b_blk;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
	);

	sha256_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_blk)
	);

	sha256_back u_back (
		.clk(clk), .arst_n(arst_n),
		.blk_valid(b_valid), .blk_ready(b_ready), .blk(b_blk),
		.out_ch(out_ch)
	);

`ifndef NO_ASSERTIONS
	// last_word is set exactly on digest word index 7
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
		else $error("last_word mismatch");
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !b_ready)
		else $error("back idle while emitting");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_word)
		|=> (out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 3'd1))
		else $error("digest index skipped");
`endif
endmodule

// ----- tb/tb_sha256_message_hasher_core.sv -----
module tb_sha256_message_hasher_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Input word as queued for the driver.
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_word_t;

	// One expected digest word.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	// Round constants, listed locally so the predictor stays independent of the RTL.
	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic clk;
	logic arst_n;

	sha256_in_if  in_ch();
	sha256_out_if out_ch();

	sha256_message_hasher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// ------------------------------------------------------------------
	// Predictor state: running hash, block under fill, fill position and
	// the 64-bit bit count, which wraps.
	// ------------------------------------------------------------------
	logic [31:0] hash_acc [8];
	logic [7:0]  blk_bytes [64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;

	in_word_t pending_words [$];
	digest_t  digest_queue [$];
	int unsigned fail_count;

	// Idle percentages; changed by the stimulus phases.
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	// Long receiver hold-off, in cycles, counted down in its own process.
	int unsigned hold_cycles;

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of blk_bytes into hash_acc.
	task automatic compress_blk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hash_acc[0], hash_acc[1], hash_acc[2], hash_acc[3],
			hash_acc[4], hash_acc[5], hash_acc[6], hash_acc[7]};
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundK[r] + w[r];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
		hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
	endtask

	task automatic push_byte(logic [7:0] b);
		blk_bytes[blk_fill] = b;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_blk();
			blk_fill = 0;
		end
	endtask

	task automatic clear_hash_state();
		hash_acc = InitHash;
		blk_fill = 0;
		msg_bits = '0;
	endtask

	// Advance the predictor by one accepted word; on end of message pad,
	// append the length (spilling into an extra block when needed) and
	// queue the eight digest words.
	task automatic predict_hash(in_word_t wd);
		logic [63:0] len;
		digest_t dg;
		if (wd.has_byte) begin
			push_byte(wd.msg_byte);
			msg_bits += 64'd8;
		end
		if (wd.end_of_message) begin
			len = msg_bits;
			push_byte(8'h80);
			while (blk_fill != 56)
				push_byte(8'h00);
			for (int i = 0; i < 8; i++)
				push_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				dg.digest_word = hash_acc[i];
				dg.word_index  = i[2:0];
				dg.last_word   = (i == 7);
				digest_queue.push_back(dg);
			end
			clear_hash_state();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Driver: offers the head of pending_words, idling at random. The
	// predictor runs on the word at the edge where it is accepted.
	// ------------------------------------------------------------------
	initial begin
		in_ch.valid = 1'b0;
		in_ch.msg_byte = '0;
		in_ch.has_byte = 1'b0;
		in_ch.end_of_message = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		logic offer;
		in_word_t nxt;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_hash(pending_words.pop_front());
			end
			// Keep the current word up until it is taken.
			if (in_ch.valid && !in_ch.ready) begin
				offer = 1'b1;
			end else begin
				offer = pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct;
			end
			if (offer) begin
				nxt = pending_words[0];
				in_ch.valid <= 1'b1;
				in_ch.msg_byte <= nxt.msg_byte;
				in_ch.has_byte <= nxt.has_byte;
				in_ch.end_of_message <= nxt.end_of_message;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Hold-off counter.
	always @(posedge clk) begin
		if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted digest word against the oldest
	// expectation and drives ready, including the long hold-off.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		digest_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected word", out_ch.digest_word, '0);
				end else begin
					want = digest_queue.pop_front();
					if (out_ch.digest_word !== want.digest_word)
						report_mismatch("digest_word", out_ch.digest_word, want.digest_word);
					if (out_ch.word_index !== want.word_index)
						report_mismatch("word_index", out_ch.word_index, want.word_index);
					if (out_ch.last_word !== want.last_word)
						report_mismatch("last_word", out_ch.last_word, want.last_word);
				end
			end
			if (hold_cycles != 0) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= snk_idle_pct;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic in_word_t mk(logic [7:0] b, logic hb, logic eom);
		in_word_t w;
		w.msg_byte = b;
		w.has_byte = hb;
		w.end_of_message = eom;
		return w;
	endfunction

	// Queue a message of n random bytes; the last byte may carry the end
	// mark, or a separate byteless terminator closes it.
	task automatic queue_msg(int unsigned n);
		bit sep_end;
		sep_end = (n == 0) || ($urandom_range(3) == 0);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				pending_words.push_back(mk(8'($urandom), 1'b0, 1'b0));
			pending_words.push_back(mk(8'($urandom), 1'b1, !sep_end && i == n - 1));
		end
		if (sep_end)
			pending_words.push_back(mk(8'($urandom), 1'b0, 1'b1));
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || digest_queue.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		fail_count = 0;
		hold_cycles = 0;
		src_idle_pct = 13;
		snk_idle_pct = 85;
		clear_hash_state();
		@(posedge arst_n);

		// Directed: empty message, one 0x00 byte, one 0xff byte, byteless
		// idle word, and the lengths around the padding spill (55, 56, 64).
		pending_words.push_back(mk(8'h00, 1'b0, 1'b0));
		pending_words.push_back(mk(8'ha5, 1'b0, 1'b1));
		pending_words.push_back(mk(8'h00, 1'b1, 1'b1));
		pending_words.push_back(mk(8'hff, 1'b1, 1'b0));
		pending_words.push_back(mk(8'h00, 1'b0, 1'b0));
		pending_words.push_back(mk(8'h00, 1'b0, 1'b1));
		queue_msg(3);
		wait_drained();
		queue_msg(55);
		queue_msg(56);
		queue_msg(64);
		wait_drained();

		// Random messages, mostly short, a few spanning several blocks;
		// idling swapped first, then none.
		src_idle_pct = 85;
		snk_idle_pct = 13;
		sent = 0;
		while (sent < 150) begin
			if (sent > 75) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(100, 64) : $urandom_range(20);
			queue_msg(n);
			sent += n + 1;
			wait_drained();
		end

		// Long receiver stall while the sender keeps offering: the back
		// sits on the first digest, later short messages fill the block
		// queue and the input stalls.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_cycles = 1500;
		queue_msg(70);
		for (int k = 0; k < 6; k++)
			queue_msg(5);
		wait_drained();

		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
